// ----- rtl/core/pqc_pkg.sv -----
// Shared types and constants for the pending queue with cancel block.
`default_nettype none

package pqc_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int ID_W         = 16;
  localparam int ACT_W        = 2;
  localparam int ST_W         = 3;
  localparam int CNT_OUT_W    = 5;

  // Action codes; bit 1 set always means process.
  localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
  localparam int               ACT_PROC_BIT = 1;

  typedef enum logic [ST_W-1:0] {
    STS_ADDED     = 3'd0,
    STS_REMOVED   = 3'd1,
    STS_NOTFOUND  = 3'd2,
    STS_PROCESSED = 3'd3,
    STS_NONE      = 3'd4,
    STS_FULL      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_REMOVE,
    OP_PROCESS
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic            exec;
    op_t             op;
    logic [ID_W-1:0] id;
  } cmd_t;

  // Summary handed back from the chain to the control logic.
  typedef struct packed {
    logic            found;
    logic [ID_W-1:0] head_id;
  } chain_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/pending_queue_with_cancel_core.sv -----
// Top level of the pending queue with cancel: command control, entry count and result register.
// An accepted request first passes the EXEC state; its result and strobe are then
// registered in the result register.
// A new request is refused while busy; busy is high for the single cycle in which
// the cell chain compares, shifts and writes in parallel.
// The result is registered and shown for one cycle while the next request is taken.
// Synchronous active-low reset empties the queue and clears busy and the strobe.
`default_nettype none

module pending_queue_with_cancel_core #(
  parameter int CAPACITY = pqc_pkg::CAPACITY_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [pqc_pkg::ACT_W-1:0]      in_action,
  input  wire logic [pqc_pkg::ID_W-1:0]       in_order_id,
  output logic                                out_valid,
  output logic [pqc_pkg::ST_W-1:0]            out_status,
  output logic [pqc_pkg::ID_W-1:0]            out_id,
  output logic [pqc_pkg::CNT_OUT_W-1:0]       out_pending_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  pqc_pkg::state_t          state_r, state_nxt;
  pqc_pkg::op_t             op_r, op_nxt;
  logic [pqc_pkg::ID_W-1:0] id_r, id_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic                     out_valid_r, out_valid_nxt;
  pqc_pkg::status_t         status_r, status_nxt;
  logic [pqc_pkg::ID_W-1:0] out_id_r, out_id_nxt;
  logic                     accept;
  logic                     exec;
  pqc_pkg::cmd_t            cmd;
  pqc_pkg::chain_stat_t     stat;
  logic [CW+pqc_pkg::CNT_OUT_W-1:0] count_ext;

  assign accept = start && !busy;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pqc_pkg::ST_IDLE: if (start) state_nxt = pqc_pkg::ST_EXEC;
      pqc_pkg::ST_EXEC: state_nxt = pqc_pkg::ST_IDLE;
      default:          state_nxt = pqc_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy = 1'b0;
    exec = 1'b0;
    unique case (state_r)
      pqc_pkg::ST_IDLE: ;
      pqc_pkg::ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      default: ;
    endcase
  end

  // Request capture; bit 1 of the action wins over the other codes.
  always_comb begin
    op_nxt = op_r;
    id_nxt = id_r;
    if (accept) begin
      id_nxt = in_order_id;
      priority if (in_action[pqc_pkg::ACT_PROC_BIT]) begin
        op_nxt = pqc_pkg::OP_PROCESS;
      end else if (in_action == pqc_pkg::ACT_REMOVE) begin
        op_nxt = pqc_pkg::OP_REMOVE;
      end else begin
        op_nxt = pqc_pkg::OP_ADD;
      end
    end
  end

  // A full queue refuses an add, so the cells see no write then.
  always_comb begin
    cmd.op   = op_r;
    cmd.id   = id_r;
    cmd.exec = exec && !(op_r == pqc_pkg::OP_ADD && count_r == CW'(CAPACITY));
  end

  pqc_chain #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_chain (
    .clk   (clk),
    .cmd   (cmd),
    .count (count_r),
    .stat  (stat)
  );

  // Result and count update.
  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_id_nxt    = out_id_r;
    out_valid_nxt = exec;
    if (exec) begin
      out_id_nxt = '0;
      unique case (op_r)
        pqc_pkg::OP_ADD: begin
          if (count_r == CW'(CAPACITY)) begin
            status_nxt = pqc_pkg::STS_FULL;
          end else begin
            status_nxt = pqc_pkg::STS_ADDED;
            count_nxt  = count_r + CW'(1);
          end
        end
        pqc_pkg::OP_REMOVE: begin
          if (stat.found) begin
            status_nxt = pqc_pkg::STS_REMOVED;
            out_id_nxt = id_r;
            count_nxt  = count_r - CW'(1);
          end else begin
            status_nxt = pqc_pkg::STS_NOTFOUND;
          end
        end
        pqc_pkg::OP_PROCESS: begin
          if (count_r == '0) begin
            status_nxt = pqc_pkg::STS_NONE;
          end else begin
            status_nxt = pqc_pkg::STS_PROCESSED;
            out_id_nxt = stat.head_id;
            count_nxt  = count_r - CW'(1);
          end
        end
        default: status_nxt = pqc_pkg::STS_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pqc_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    id_r     <= id_nxt;
    status_r <= status_nxt;
    out_id_r <= out_id_nxt;
  end

  // The count port is the low five bits of the entry count.
  assign count_ext         = {{pqc_pkg::CNT_OUT_W{1'b0}}, count_r};
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_id            = out_id_r;
  assign out_pending_count = count_ext[pqc_pkg::CNT_OUT_W-1:0];

endmodule

`default_nettype wire

// ----- rtl/core/pqc_cell.sv -----
// One storage cell of the pending queue: holds one id and shifts it towards the head.
`default_nettype none

module pqc_cell #(
  parameter int INDEX = 0,
  parameter int CW    = 5
) (
  input  wire logic                  clk,
  input  wire pqc_pkg::cmd_t         cmd,
  input  wire logic [CW-1:0]         count,
  input  wire logic                  found,
  input  wire logic [pqc_pkg::ID_W-1:0] up_id,
  input  wire logic                  above_in,
  output logic                       above_out,
  output logic [pqc_pkg::ID_W-1:0]   id_q
);

  logic [pqc_pkg::ID_W-1:0] id_r;
  logic [pqc_pkg::ID_W-1:0] id_nxt;
  logic                     valid;
  logic                     match;

  assign valid     = CW'(INDEX) < count;
  assign match     = (cmd.op == pqc_pkg::OP_REMOVE) && valid && (id_r == cmd.id);
  assign above_out = above_in | match;
  assign id_q      = id_r;

  // On a removal, every cell from the newest match upwards takes its upper neighbour.
  always_comb begin
    id_nxt = id_r;
    if (cmd.exec) begin
      priority if (cmd.op == pqc_pkg::OP_ADD && count == CW'(INDEX)) begin
        id_nxt = cmd.id;
      end else if (cmd.op == pqc_pkg::OP_PROCESS) begin
        id_nxt = up_id;
      end else if (cmd.op == pqc_pkg::OP_REMOVE && found && !above_in) begin
        id_nxt = up_id;
      end else begin
        id_nxt = id_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r <= id_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/core/pqc_chain.sv -----
// Row of queue cells, oldest entry at cell zero, with the match chain running downwards.
`default_nettype none

module pqc_chain #(
  parameter int CAPACITY = pqc_pkg::CAPACITY_DEF,
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  wire logic                 clk,
  input  wire pqc_pkg::cmd_t        cmd,
  input  wire logic [CW-1:0]        count,
  output pqc_pkg::chain_stat_t      stat
);

  logic [pqc_pkg::ID_W-1:0] id_w [CAPACITY];
  logic [CAPACITY:0]        above;

  assign above[CAPACITY] = 1'b0;
  assign stat.found      = above[0];
  assign stat.head_id    = id_w[0];

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [pqc_pkg::ID_W-1:0] up_id;
    if (k == CAPACITY - 1) begin : g_top
      assign up_id = id_w[k];
    end else begin : g_mid
      assign up_id = id_w[k+1];
    end

    pqc_cell #(
      .INDEX (k),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .count     (count),
      .found     (above[0]),
      .up_id     (up_id),
      .above_in  (above[k+1]),
      .above_out (above[k]),
      .id_q      (id_w[k])
    );
  end

endmodule

`default_nettype wire

// ----- rtl/core/pqc_checker.sv -----
// Port-level checks for the pending queue with cancel, bound to the top level.
`default_nettype none

module pqc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic [pqc_pkg::ST_W-1:0]       out_status,
  input wire logic [pqc_pkg::ID_W-1:0]       out_id,
  input wire logic [pqc_pkg::CNT_OUT_W-1:0]  out_pending_count
);

  // An accepted request raises busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // Every busy cycle is followed by exactly one result strobe.
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> out_valid && !busy)
    else $error("busy cycle not followed by a result");

  // A strobe never appears without a request having been worked on.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding request");

  // Only a removal or a hand-off carries an id.
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == pqc_pkg::STS_ADDED || out_status == pqc_pkg::STS_FULL ||
                  out_status == pqc_pkg::STS_NOTFOUND || out_status == pqc_pkg::STS_NONE)
    |-> out_id == '0)
    else $error("id reported on a request that moves no entry");

  // Nothing pending means the count shows zero.
  a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == pqc_pkg::STS_NONE |-> out_pending_count == '0)
    else $error("none pending reported with a non-zero count");

endmodule

bind pending_queue_with_cancel_core pqc_checker u_pqc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_status        (out_status),
  .out_id            (out_id),
  .out_pending_count (out_pending_count)
);

`default_nettype wire

// ----- sim/pending_queue_with_cancel_core_test.sv -----
// Self-checking testbench for the pending queue with cancel core.
`timescale 1ns / 1ps

module pending_queue_with_cancel_core_test;

  localparam int QDEPTH = pqc_pkg::CAPACITY_DEF;
  // Both codes with bit 1 set mean process.
  localparam logic [pqc_pkg::ACT_W-1:0] ACT_PROCESS     = 2'd2;
  localparam logic [pqc_pkg::ACT_W-1:0] ACT_PROCESS_ALT = 2'd3;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 100;

  typedef struct packed {
    pqc_pkg::status_t              status;
    logic [pqc_pkg::ID_W-1:0]      id;
    logic [pqc_pkg::CNT_OUT_W-1:0] count;
  } queue_result_t;

  class queue_tracker;
    logic [pqc_pkg::ID_W-1:0] ids [QDEPTH];
    int unsigned     count;
    queue_result_t   awaited [$];
    int unsigned     errors;
    int unsigned     seen [6];

    function new();
      count  = 0;
      errors = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void close_gap(int unsigned pos);
      for (int unsigned k = pos; k + 1 < count; k++) ids[k] = ids[k + 1];
      count--;
    endfunction

    // Works out the result of one accepted request and updates the model store.
    function void note_request(logic [pqc_pkg::ACT_W-1:0] act, logic [pqc_pkg::ID_W-1:0] oid);
      queue_result_t r;
      int            pos;
      r.id = '0;
      pos  = -1;
      if (act[pqc_pkg::ACT_PROC_BIT]) begin
        if (count == 0) begin
          r.status = pqc_pkg::STS_NONE;
        end else begin
          r.id = ids[0];
          close_gap(0);
          r.status = pqc_pkg::STS_PROCESSED;
        end
      end else if (act == pqc_pkg::ACT_REMOVE) begin
        for (int k = int'(count) - 1; k >= 0 && pos < 0; k--)
          if (ids[k] == oid) pos = k;
        if (pos >= 0) begin
          r.id = ids[pos];
          close_gap(pos);
          r.status = pqc_pkg::STS_REMOVED;
        end else begin
          r.status = pqc_pkg::STS_NOTFOUND;
        end
      end else begin
        if (count >= QDEPTH) begin
          r.status = pqc_pkg::STS_FULL;
        end else begin
          ids[count] = oid;
          count++;
          r.status = pqc_pkg::STS_ADDED;
        end
      end
      r.count = count[pqc_pkg::CNT_OUT_W-1:0];
      awaited.push_back(r);
      seen[r.status]++;
    endfunction

    function void field_check(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [pqc_pkg::ST_W-1:0] st, logic [pqc_pkg::ID_W-1:0] oid,
                               logic [pqc_pkg::CNT_OUT_W-1:0] cnt);
      queue_result_t e;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual status %0d id %0d count %0d",
                 $time, st, oid, cnt);
      end else begin
        e = awaited.pop_front();
        field_check("status", e.status, st);
        field_check("out_id", e.id, oid);
        field_check("pending_count", e.count, cnt);
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [pqc_pkg::ACT_W-1:0]     in_action;
  logic [pqc_pkg::ID_W-1:0]      in_order_id;
  logic                          out_valid;
  logic [pqc_pkg::ST_W-1:0]      out_status;
  logic [pqc_pkg::ID_W-1:0]      out_id;
  logic [pqc_pkg::CNT_OUT_W-1:0] out_pending_count;

  queue_tracker             tracker = new();
  int unsigned              requests_sent;
  logic [pqc_pkg::ID_W-1:0] id_pool [6];

  pending_queue_with_cancel_core #(.CAPACITY(QDEPTH)) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_action         (in_action),
    .in_order_id       (in_order_id),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_id            (out_id),
    .out_pending_count (out_pending_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid) tracker.check_result(out_status, out_id, out_pending_count);
  end

  // Holds the request until an edge finds the block free.
  task automatic send_request(input logic [pqc_pkg::ACT_W-1:0] act,
                              input logic [pqc_pkg::ID_W-1:0] oid);
    in_action   <= act;
    in_order_id <= oid;
    start       <= 1'b1;
    do @(posedge clk); while (busy);
    tracker.note_request(act, oid);
    requests_sent++;
  endtask

  // Drops start with junk on the request fields and waits idle.
  task automatic idle_cycles(input int unsigned n);
    start       <= 1'b0;
    in_action   <= pqc_pkg::ACT_W'($urandom);
    in_order_id <= pqc_pkg::ID_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [pqc_pkg::ID_W-1:0] pick_id(int unsigned pool_pct);
    if ($urandom_range(0, 99) < pool_pct) return id_pool[$urandom_range(0, 5)];
    return pqc_pkg::ID_W'($urandom_range(0, 65535));
  endfunction

  initial begin
    int unsigned add_pct;
    int unsigned r;
    bit          gaps_on;

    requests_sent = 0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_action   = pqc_pkg::ACT_ADD;
    in_order_id = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: process under both codes and a remove with nothing to match.
    send_request(ACT_PROCESS, 16'h0000);
    send_request(ACT_PROCESS_ALT, 16'hFFFF);
    send_request(pqc_pkg::ACT_REMOVE, 16'h1234);
    send_request(pqc_pkg::ACT_ADD, 16'h0000);
    send_request(pqc_pkg::ACT_ADD, 16'hFFFF);
    send_request(pqc_pkg::ACT_REMOVE, 16'hFFFF);
    send_request(pqc_pkg::ACT_REMOVE, 16'hAAAA);
    // Duplicates: the newer copy must be the one that goes.
    send_request(pqc_pkg::ACT_ADD, 16'hAAAA);
    send_request(pqc_pkg::ACT_ADD, 16'hAAAA);
    send_request(pqc_pkg::ACT_ADD, 16'h5555);
    send_request(pqc_pkg::ACT_REMOVE, 16'hAAAA);
    send_request(ACT_PROCESS_ALT, 16'hAAAA);
    // Fill to capacity, then one add that must be refused.
    for (int k = 0; k < QDEPTH - 1; k++) send_request(pqc_pkg::ACT_ADD, 16'h0001 << k);
    send_request(ACT_PROCESS, 16'h5555);
    idle_cycles(2);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      add_pct = $urandom_range(20, 85);
      gaps_on = (ph != RAND_PHASES - 1) && ($urandom_range(0, 3) != 0);
      foreach (id_pool[i]) id_pool[i] = pqc_pkg::ID_W'($urandom);
      id_pool[0] = (ph % 2) ? 16'hFFFF : 16'h0000;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (gaps_on && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 4));
        r = $urandom_range(0, 99);
        if (r < add_pct)
          send_request(pqc_pkg::ACT_ADD, pick_id(80));
        else if (r < add_pct + (100 - add_pct) / 2)
          send_request(pqc_pkg::ACT_REMOVE, pick_id(75));
        else
          send_request(($urandom_range(0, 4) == 0) ? ACT_PROCESS_ALT : ACT_PROCESS,
                       pqc_pkg::ID_W'($urandom));
      end
      // Let the block empty its pipeline once in the middle of the run.
      if (ph == RAND_PHASES / 2) wait_drained();
    end

    wait_drained();
    repeat (6) @(posedge clk);
    $display("Ran %0d requests: %0d added, %0d removed, %0d not found,", requests_sent,
             tracker.seen[pqc_pkg::STS_ADDED], tracker.seen[pqc_pkg::STS_REMOVED],
             tracker.seen[pqc_pkg::STS_NOTFOUND]);
    $display("  %0d processed, %0d on an empty store, %0d refused as full.",
             tracker.seen[pqc_pkg::STS_PROCESSED], tracker.seen[pqc_pkg::STS_NONE],
             tracker.seen[pqc_pkg::STS_FULL]);
    if (tracker.errors == 0 && tracker.awaited.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("%0t: timeout with %0d results outstanding", $time, tracker.awaited.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
